FILE: hdl/ebalu_pkg.sv
`default_nettype none
package ebalu_pkg;

  // Field widths of the stream items.
  localparam int MODE_W    = 5;
  localparam int BYTE_W    = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // Bit positions inside the input tdata word.
  localparam int IN_MODE_LSB = 0;
  localparam int IN_A_LSB    = IN_MODE_LSB + MODE_W;
  localparam int IN_B_LSB    = IN_A_LSB + BYTE_W;
  localparam int IN_Z_BIT    = IN_B_LSB + BYTE_W;
  localparam int IN_N_BIT    = IN_Z_BIT + 1;
  localparam int IN_H_BIT    = IN_N_BIT + 1;
  localparam int IN_C_BIT    = IN_H_BIT + 1;

  // Bit positions inside the output tdata word.
  localparam int OUT_RES_LSB = 0;
  localparam int OUT_WR_BIT  = OUT_RES_LSB + BYTE_W;
  localparam int OUT_Z_BIT   = OUT_WR_BIT + 1;
  localparam int OUT_N_BIT   = OUT_Z_BIT + 1;
  localparam int OUT_H_BIT   = OUT_N_BIT + 1;
  localparam int OUT_C_BIT   = OUT_H_BIT + 1;
  localparam int OUT_PAD_W   = OUT_DATA_W - (OUT_C_BIT + 1);

  // Decimal adjust constants.
  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] ADJ_HI    = 8'h60;
  localparam logic [7:0] ADJ_LO    = 8'h06;
  localparam logic [3:0] NIB_MAX   = 4'h9;
  localparam logic [3:0] NIB_FULL  = 4'hF;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLC  = 5'd10,
    OP_RRC  = 5'd11,
    OP_RL   = 5'd12,
    OP_RR   = 5'd13,
    OP_SWAP = 5'd14,
    OP_DAA  = 5'd15,
    OP_CPL  = 5'd16,
    OP_CCF  = 5'd17,
    OP_SCF  = 5'd18,
    OP_RLCA = 5'd19,
    OP_RRCA = 5'd20,
    OP_RLA  = 5'd21,
    OP_RRA  = 5'd22
  } op_t;

  // Source of the result byte in the execute stage.
  typedef enum logic [1:0] {
    SEL_SUM,
    SEL_AND,
    SEL_XOR,
    SEL_OR_PRE
  } sel_t;

  // How the zero flag is formed.
  typedef enum logic [1:0] {
    Z_RES,
    Z_SUM,
    Z_FIX
  } zmode_t;

  // Decode stage to execute stage.
  typedef struct packed {
    sel_t        sel;
    logic        use_or;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  y;
    logic        cin;
    logic        borrow;
    logic [7:0]  pre;
    logic        h_adder;
    logic        h_fix;
    logic        c_adder;
    logic        c_fix;
    logic        n;
    logic        wr;
    zmode_t      zmode;
    logic        z_fix;
  } dec_t;

  // Execute stage to flag stage.
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] zt;
    logic       z_test;
    logic       z_fix;
    logic       wr;
    logic       n;
    logic       h;
    logic       c;
  } exe_t;

  // Flag stage output.
  typedef struct packed {
    logic [7:0] result;
    logic       wr;
    logic       z;
    logic       n;
    logic       h;
    logic       c;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/ebalu_decode.sv
`default_nettype none
module ebalu_decode
  import ebalu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [7:0]        operand_a,
  input  wire logic [7:0]        operand_b,
  input  wire logic              zero_in,
  input  wire logic              subtract_in,
  input  wire logic              half_carry_in,
  input  wire logic              carry_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dec_t                   out_data
);

  dec_t       dec_next;
  logic [7:0] adj;
  logic       hi_fix;
  logic       lo_fix;

  assign in_ready = !out_valid || out_ready;

  // Operand preparation: subtraction is done as an add of the inverted
  // operand, so add and subtract share the adders of the execute stage.
  always_comb begin
    dec_next         = '0;
    adj              = '0;
    hi_fix           = carry_in || (operand_a > DAA_LIMIT);
    lo_fix           = half_carry_in || (operand_a[3:0] > NIB_MAX);
    dec_next.sel     = SEL_OR_PRE;
    dec_next.use_or  = 1'b0;
    dec_next.a       = operand_a;
    dec_next.b       = operand_b;
    dec_next.y       = operand_b;
    dec_next.cin     = 1'b0;
    dec_next.borrow  = 1'b0;
    dec_next.pre     = operand_a;
    dec_next.h_adder = 1'b0;
    dec_next.h_fix   = half_carry_in;
    dec_next.c_adder = 1'b0;
    dec_next.c_fix   = carry_in;
    dec_next.n       = subtract_in;
    dec_next.wr      = 1'b1;
    dec_next.zmode   = Z_RES;
    dec_next.z_fix   = zero_in;
    case (op_t'(mode))
      OP_ADD, OP_ADC: begin
        dec_next.sel     = SEL_SUM;
        dec_next.cin     = (op_t'(mode) == OP_ADC) ? carry_in : 1'b0;
        dec_next.h_adder = 1'b1;
        dec_next.c_adder = 1'b1;
        dec_next.n       = 1'b0;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        dec_next.sel     = SEL_SUM;
        dec_next.y       = ~operand_b;
        dec_next.cin     = (op_t'(mode) == OP_SBC) ? !carry_in : 1'b1;
        dec_next.borrow  = 1'b1;
        dec_next.h_adder = 1'b1;
        dec_next.c_adder = 1'b1;
        dec_next.n       = 1'b1;
        if (op_t'(mode) == OP_CP) begin
          // Compare keeps the accumulator; Z comes from the difference.
          dec_next.sel   = SEL_OR_PRE;
          dec_next.wr    = 1'b0;
          dec_next.zmode = Z_SUM;
        end
      end
      OP_AND: begin
        dec_next.sel   = SEL_AND;
        dec_next.h_fix = 1'b1;
        dec_next.c_fix = 1'b0;
        dec_next.n     = 1'b0;
      end
      OP_XOR: begin
        dec_next.sel   = SEL_XOR;
        dec_next.h_fix = 1'b0;
        dec_next.c_fix = 1'b0;
        dec_next.n     = 1'b0;
      end
      OP_OR: begin
        dec_next.sel    = SEL_OR_PRE;
        dec_next.use_or = 1'b1;
        dec_next.h_fix  = 1'b0;
        dec_next.c_fix  = 1'b0;
        dec_next.n      = 1'b0;
      end
      OP_INC: begin
        dec_next.sel   = SEL_SUM;
        dec_next.y     = BYTE_ONE;
        dec_next.h_fix = (operand_a[3:0] == NIB_FULL);
        dec_next.n     = 1'b0;
      end
      OP_DEC: begin
        dec_next.sel   = SEL_SUM;
        dec_next.y     = BYTE_ONES;
        dec_next.h_fix = (operand_a[3:0] == 4'h0);
        dec_next.n     = 1'b1;
      end
      OP_RLC, OP_RLCA: begin
        dec_next.pre   = {operand_a[6:0], operand_a[7]};
        dec_next.c_fix = operand_a[7];
        dec_next.h_fix = 1'b0;
        dec_next.n     = 1'b0;
      end
      OP_RRC, OP_RRCA: begin
        dec_next.pre   = {operand_a[0], operand_a[7:1]};
        dec_next.c_fix = operand_a[0];
        dec_next.h_fix = 1'b0;
        dec_next.n     = 1'b0;
      end
      OP_RL, OP_RLA: begin
        dec_next.pre   = {operand_a[6:0], carry_in};
        dec_next.c_fix = operand_a[7];
        dec_next.h_fix = 1'b0;
        dec_next.n     = 1'b0;
      end
      OP_RR, OP_RRA: begin
        dec_next.pre   = {carry_in, operand_a[7:1]};
        dec_next.c_fix = operand_a[0];
        dec_next.h_fix = 1'b0;
        dec_next.n     = 1'b0;
      end
      OP_SWAP: begin
        dec_next.pre   = {operand_a[3:0], operand_a[7:4]};
        dec_next.c_fix = 1'b0;
        dec_next.h_fix = 1'b0;
        dec_next.n     = 1'b0;
      end
      OP_DAA: begin
        if (!subtract_in) begin
          adj            = (hi_fix ? ADJ_HI : 8'h00) | (lo_fix ? ADJ_LO : 8'h00);
          dec_next.y     = adj;
          dec_next.c_fix = hi_fix;
        end else begin
          adj          = (carry_in ? ADJ_HI : 8'h00) | (half_carry_in ? ADJ_LO : 8'h00);
          dec_next.y   = ~adj;
          dec_next.cin = 1'b1;
        end
        dec_next.sel   = SEL_SUM;
        dec_next.h_fix = 1'b0;
      end
      OP_CPL: begin
        dec_next.pre   = ~operand_a;
        dec_next.n     = 1'b1;
        dec_next.h_fix = 1'b1;
        dec_next.zmode = Z_FIX;
      end
      OP_CCF, OP_SCF: begin
        dec_next.wr    = 1'b0;
        dec_next.n     = 1'b0;
        dec_next.h_fix = 1'b0;
        dec_next.c_fix = (op_t'(mode) == OP_SCF) ? 1'b1 : !carry_in;
        dec_next.zmode = Z_FIX;
      end
      default: begin
        // Unused codes pass the accumulator and all flags unchanged.
        dec_next.wr    = 1'b0;
        dec_next.zmode = Z_FIX;
      end
    endcase
    // The accumulator rotates always clear Z.
    if (op_t'(mode) == OP_RLCA || op_t'(mode) == OP_RRCA ||
        op_t'(mode) == OP_RLA || op_t'(mode) == OP_RRA) begin
      dec_next.zmode = Z_FIX;
      dec_next.z_fix = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= dec_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ebalu_exec.sv
`default_nettype none
module ebalu_exec
  import ebalu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire dec_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output exe_t      out_data
);

  logic [8:0] sum9;
  logic [4:0] nib5;
  logic [7:0] pre_or;
  exe_t       exe_next;

  assign in_ready = !out_valid || out_ready;

  // Carries of the inverted-operand add are inverted to give borrows.
  always_comb begin
    sum9   = {1'b0, in_data.a} + {1'b0, in_data.y} + {8'b0, in_data.cin};
    nib5   = {1'b0, in_data.a[3:0]} + {1'b0, in_data.y[3:0]} + {4'b0, in_data.cin};
    pre_or = in_data.use_or ? (in_data.a | in_data.b) : in_data.pre;
    exe_next = '0;
    case (in_data.sel)
      SEL_SUM:    exe_next.result = sum9[7:0];
      SEL_AND:    exe_next.result = in_data.a & in_data.b;
      SEL_XOR:    exe_next.result = in_data.a ^ in_data.b;
      SEL_OR_PRE: exe_next.result = pre_or;
      default:    exe_next.result = in_data.pre;
    endcase
    exe_next.zt     = (in_data.zmode == Z_SUM) ? sum9[7:0] : exe_next.result;
    exe_next.z_test = (in_data.zmode != Z_FIX);
    exe_next.z_fix  = in_data.z_fix;
    exe_next.wr     = in_data.wr;
    exe_next.n      = in_data.n;
    exe_next.h      = in_data.h_adder ? (nib5[4] ^ in_data.borrow) : in_data.h_fix;
    exe_next.c      = in_data.c_adder ? (sum9[8] ^ in_data.borrow) : in_data.c_fix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= exe_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ebalu_flags.sv
`default_nettype none
module ebalu_flags
  import ebalu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire exe_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  res_t res_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    res_next.result = in_data.result;
    res_next.wr     = in_data.wr;
    res_next.z      = in_data.z_test ? (in_data.zt == 8'h00) : in_data.z_fix;
    res_next.n      = in_data.n;
    res_next.h      = in_data.h;
    res_next.c      = in_data.c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= res_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/eight_bit_alu_with_flags.sv
// Eight-bit ALU with the Z, N, H and C flags in the style of a small 8-bit CPU core.
// Each input transfer carries an operation code, the accumulator, a second operand
// and the current flags; each output transfer carries the result byte, a write enable
// for the destination and the new flags. The block holds no state between items.
// It is a three-stage pipeline (decode, add/logic, flag forming); a result passes
// the decode, execute and flag registers before it is offered, and one item is taken
// in every cycle while the output side is ready. Each stage has its own valid bit and
// a stage only holds when it is full and the stage after it is stalled, so the input
// keeps accepting while a result waits in the output register, until the stages fill.
`default_nettype none
module eight_bit_alu_with_flags
  import ebalu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // Fields from bit 0 up: mode[4:0], operand_a[7:0], operand_b[7:0], zero_in,
  // subtract_in, half_carry_in, carry_in, then unused bits.
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // Fields from bit 0 up: result[7:0], write_result, zero_out, subtract_out,
  // half_carry_out, carry_out, then zero padding.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  logic dec_valid;
  logic exe_ready;
  dec_t dec_data;
  logic exe_valid;
  logic flg_ready;
  exe_t exe_data;
  res_t res_data;

  // Stage one: operand preparation and control decode.
  ebalu_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .mode          (s_axis_tdata[IN_MODE_LSB +: MODE_W]),
    .operand_a     (s_axis_tdata[IN_A_LSB +: BYTE_W]),
    .operand_b     (s_axis_tdata[IN_B_LSB +: BYTE_W]),
    .zero_in       (s_axis_tdata[IN_Z_BIT]),
    .subtract_in   (s_axis_tdata[IN_N_BIT]),
    .half_carry_in (s_axis_tdata[IN_H_BIT]),
    .carry_in      (s_axis_tdata[IN_C_BIT]),
    .out_valid     (dec_valid),
    .out_ready     (exe_ready),
    .out_data      (dec_data)
  );

  // Stage two: the shared adder, the logic operations and the result select.
  ebalu_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (exe_ready),
    .in_data   (dec_data),
    .out_valid (exe_valid),
    .out_ready (flg_ready),
    .out_data  (exe_data)
  );

  // Stage three: zero detect and final flags; this is the output register.
  ebalu_flags u_flags (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (exe_valid),
    .in_ready  (flg_ready),
    .in_data   (exe_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res_data)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_data.c, res_data.h, res_data.n,
                         res_data.z, res_data.wr, res_data.result};

endmodule
`default_nettype wire

FILE: hdl/ebalu_checker.sv
`default_nettype none
module ebalu_checker
  import ebalu_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_fire;
  logic s_is_cp;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign s_is_cp = (s_axis_tdata[IN_MODE_LSB +: MODE_W] == OP_CP);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // With the output side free, a result passes the decode, execute and flag registers and is then offered.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_fire ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result did not arrive after three cycles");

  // Compare returns the accumulator and does not write the destination.
  a_cp_result: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_is_cp) ##1 m_axis_tready ##1 m_axis_tready |=>
      (m_axis_tdata[OUT_WR_BIT] == 1'b0) &&
      (m_axis_tdata[OUT_RES_LSB +: BYTE_W] == $past(s_axis_tdata[IN_A_LSB +: BYTE_W], 3)))
    else $error("compare wrote or changed the result");

endmodule

bind eight_bit_alu_with_flags ebalu_checker u_ebalu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
